// File: hw/rtl/arq_pkg.sv
// ----------------------------------------------------------------------------
// arq_pkg
// Shared types and constants for the stop-and-wait link controller.
// ----------------------------------------------------------------------------
package arq_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESENDS = 1'd1;

  localparam logic [7:0] MAX_RESENDS_RST = 8'd5;
  localparam logic [7:0] RETRY_SAT       = 8'hff;
  localparam logic [15:0] NONE_AWAITED   = 16'd0;
  localparam logic [15:0] BCAST_ADDR     = 16'd0;
  localparam logic [7:0] TYPE_ACK        = 8'd0;

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_SEND_ACK   = 3'd1,
    ACT_SEND       = 3'd2,
    ACT_SEND_DELAY = 3'd3,
    ACT_RX_HDR     = 3'd4
  } action_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] dest_addr;
    logic [15:0] pkt_number;
    logic [7:0]  pkt_type;
    logic [15:0] wait_ticks;
  } arq_item_t;

  typedef struct packed {
    logic [15:0] own_id;
    logic [7:0]  max_resends;
  } arq_cfg_t;

  typedef struct packed {
    logic transmit;
    logic accepted;
    logic ack_seen;
    logic failed;
    logic timer_on;
  } arq_result_t;

endpackage

// File: hw/rtl/arq_core.sv
// ----------------------------------------------------------------------------
// arq_core
// Link state registers and the per-word update logic.
// ----------------------------------------------------------------------------
module arq_core
  import arq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  arq_item_t   item,
  input  arq_cfg_t    cfg,
  output arq_result_t res
);

  logic        timer_r,   timer_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [15:0] awaited_r, awaited_nxt;
  logic [15:0] timeout_r, timeout_nxt;
  logic [7:0]  retry_r,   retry_nxt;
  logic        fail_r,    fail_nxt;
  logic [15:0] delay_r,   delay_nxt;
  logic [15:0] lastbc_r,  lastbc_nxt;

  logic [15:0] e_inc;
  logic        tx, acc, ack, hdr_match;

  assign e_inc     = elapsed_r + 16'd1;
  assign hdr_match = (item.dest_addr == cfg.own_id) ||
                     ((item.dest_addr == BCAST_ADDR) && (item.pkt_number != lastbc_r));

  always_comb begin
    timer_nxt   = timer_r;
    elapsed_nxt = elapsed_r;
    awaited_nxt = awaited_r;
    timeout_nxt = timeout_r;
    retry_nxt   = retry_r;
    fail_nxt    = fail_r;
    delay_nxt   = delay_r;
    lastbc_nxt  = lastbc_r;
    tx  = 1'b0;
    acc = 1'b0;
    ack = 1'b0;
    case (action_t'(item.action))
      ACT_TICK: begin
        if (timer_r) begin
          elapsed_nxt = e_inc;
          // overdue ack: retransmit, timer keeps running while waiting
          if ((awaited_r != NONE_AWAITED) && (e_inc > timeout_r)) begin
            elapsed_nxt = 16'd0;
            tx          = 1'b1;
            delay_nxt   = 16'd0;
            if (retry_r != RETRY_SAT) begin
              retry_nxt = retry_r + 8'd1;
            end
          end
          if (retry_nxt > cfg.max_resends) begin
            awaited_nxt = NONE_AWAITED;
            fail_nxt    = 1'b1;
            timer_nxt   = 1'b0;
          end
          if ((delay_nxt != 16'd0) && (elapsed_nxt > delay_nxt)) begin
            delay_nxt = 16'd0;
            tx        = 1'b1;
            if (awaited_nxt == NONE_AWAITED) begin
              timer_nxt = 1'b0;
            end
          end
        end
      end
      ACT_SEND_ACK: begin
        awaited_nxt = item.pkt_number;
        timeout_nxt = item.wait_ticks;
        fail_nxt    = 1'b0;
        retry_nxt   = 8'd0;
        elapsed_nxt = 16'd0;
        timer_nxt   = (item.pkt_number != NONE_AWAITED);
        delay_nxt   = 16'd0;
        tx          = 1'b1;
      end
      ACT_SEND: begin
        tx        = 1'b1;
        delay_nxt = 16'd0;
        if (awaited_r == NONE_AWAITED) begin
          timer_nxt = 1'b0;
        end
      end
      ACT_SEND_DELAY: begin
        delay_nxt   = item.wait_ticks;
        awaited_nxt = NONE_AWAITED;
        fail_nxt    = 1'b0;
        retry_nxt   = 8'd0;
        elapsed_nxt = 16'd0;
        timer_nxt   = 1'b1;
      end
      ACT_RX_HDR: begin
        if (hdr_match) begin
          acc        = 1'b1;
          lastbc_nxt = item.pkt_number;
          if ((awaited_r != NONE_AWAITED) && (item.pkt_type == TYPE_ACK)) begin
            awaited_nxt = NONE_AWAITED;
            timer_nxt   = 1'b0;
            ack         = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.transmit = tx;
    res.accepted = acc;
    res.ack_seen = ack;
    res.failed   = fail_nxt;
    res.timer_on = timer_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r   <= 1'b0;
      elapsed_r <= 16'd0;
      awaited_r <= NONE_AWAITED;
      timeout_r <= 16'd0;
      retry_r   <= 8'd0;
      fail_r    <= 1'b0;
      delay_r   <= 16'd0;
      lastbc_r  <= 16'd0;
    end else if (fire) begin
      timer_r   <= timer_nxt;
      elapsed_r <= elapsed_nxt;
      awaited_r <= awaited_nxt;
      timeout_r <= timeout_nxt;
      retry_r   <= retry_nxt;
      fail_r    <= fail_nxt;
      delay_r   <= delay_nxt;
      lastbc_r  <= lastbc_nxt;
    end
  end

endmodule

// File: hw/rtl/ack_retransmit_controller_unit.sv
// ----------------------------------------------------------------------------
// ack_retransmit_controller_unit
// Stop-and-wait link controller: timer, retransmit and header filter.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | action, dest_addr, pkt_number,
//          |           |                    | pkt_type, wait_ticks
//  out_    | output    | out_valid/out_ready| transmit, accepted, ack_seen,
//          |           |                    | failed, timer_on
//  cfg_    | input     | cfg_wr_en          | cfg_index, cfg_wdata
//
// one word per cycle while the result side is not stalled; a word is held in
// the input register and its result is then captured in the result register.
// the state update is a single compare-and-update step.
// reset is synchronous and clears the link state and both valid flags.
// a stalled result holds; the input register keeps taking words as long as
// the result register drains or is empty.
module ack_retransmit_controller_unit
  import arq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_action,
  input  logic [15:0]           in_dest_addr,
  input  logic [15:0]           in_pkt_number,
  input  logic [7:0]            in_pkt_type,
  input  logic [15:0]           in_wait_ticks,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_transmit,
  output logic                  out_accepted,
  output logic                  out_ack_seen,
  output logic                  out_failed,
  output logic                  out_timer_on,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  arq_cfg_t    cfg_r;
  arq_item_t   item_r;
  logic        item_vld_r;
  arq_result_t res_r, res_nxt;
  logic        out_vld_r;
  logic        adv;

  assign adv      = item_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !item_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id      <= 16'd0;
      cfg_r.max_resends <= MAX_RESENDS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_OWN_ID:      cfg_r.own_id      <= cfg_wdata;
        CFG_MAX_RESENDS: cfg_r.max_resends <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.action     <= in_action;
      item_r.dest_addr  <= in_dest_addr;
      item_r.pkt_number <= in_pkt_number;
      item_r.pkt_type   <= in_pkt_type;
      item_r.wait_ticks <= in_wait_ticks;
    end
  end

  arq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_transmit = res_r.transmit;
  assign out_accepted = res_r.accepted;
  assign out_ack_seen = res_r.ack_seen;
  assign out_failed   = res_r.failed;
  assign out_timer_on = res_r.timer_on;

endmodule

// File: hw/rtl/arq_checker.sv
// ----------------------------------------------------------------------------
// arq_port_checks
// Port-level checks for the link controller, bound to the top level.
// ----------------------------------------------------------------------------
module arq_port_checks (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_transmit,
  input logic out_accepted,
  input logic out_ack_seen,
  input logic out_failed,
  input logic out_timer_on
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_transmit) &&
    $stable(out_accepted) && $stable(out_ack_seen) && $stable(out_failed) &&
    $stable(out_timer_on))
    else $error("stalled result changed");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an ack can only come from a header that passed the filter; no timer, no transmit
  a_ack_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ack_seen |-> out_accepted && !out_timer_on && !out_transmit)
    else $error("ack without accepted header");

  // failure always stops the timer
  a_fail_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_failed |-> !out_timer_on)
    else $error("timer running after failure");

endmodule

bind ack_retransmit_controller_unit arq_port_checks u_arq_checker (.*);

// File: test/arq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arq_checker
// Watches the input, result and register ports of the link controller. For
// every accepted input word it predicts the result word from its own copy of
// the link state and compares the result words in order, field by field.
// ----------------------------------------------------------------------------
module arq_checker
  import arq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [2:0]            in_action,
  input  logic [15:0]           in_dest_addr,
  input  logic [15:0]           in_pkt_number,
  input  logic [7:0]            in_pkt_type,
  input  logic [15:0]           in_wait_ticks,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_transmit,
  input  logic                  out_accepted,
  input  logic                  out_ack_seen,
  input  logic                  out_failed,
  input  logic                  out_timer_on,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    error_count,
  output int                    words_pending
);

  arq_cfg_t    link_cfg;
  logic        timer_run;
  logic [15:0] elapsed;
  logic [15:0] awaited;
  logic [15:0] timeout;
  logic [7:0]  retries;
  logic        fail_flag;
  logic [15:0] delay;
  logic [15:0] last_bcast;
  arq_result_t expected_results[$];
  int          errs = 0;

  // indexed by bit position in arq_result_t
  string field_name[5] = '{"timer_on", "failed", "ack_seen", "accepted", "transmit"};

  function automatic void clear_link();
    link_cfg.own_id      = '0;
    link_cfg.max_resends = MAX_RESENDS_RST;
    timer_run  = 1'b0;
    elapsed    = '0;
    awaited    = NONE_AWAITED;
    timeout    = '0;
    retries    = '0;
    fail_flag  = 1'b0;
    delay      = '0;
    last_bcast = '0;
  endfunction

  // caller raises transmit
  function automatic void send_held();
    delay = '0;
    if (awaited == NONE_AWAITED) begin
      timer_run = 1'b0;
    end
  endfunction

  function automatic void start_timer();
    fail_flag = 1'b0;
    retries   = '0;
    elapsed   = '0;
    timer_run = 1'b1;
  endfunction

  function automatic arq_result_t link_step(arq_item_t w);
    arq_result_t r;
    r = '0;
    case (w.action)
      ACT_TICK: begin
        if (timer_run) begin
          elapsed = elapsed + 16'd1;
          if (awaited != NONE_AWAITED && elapsed > timeout) begin
            elapsed = '0;
            send_held();
            r.transmit = 1'b1;
            if (retries != RETRY_SAT) begin
              retries = retries + 8'd1;
            end
          end
          if (retries > link_cfg.max_resends) begin
            awaited   = NONE_AWAITED;
            fail_flag = 1'b1;
            timer_run = 1'b0;
          end
          if (delay != '0 && elapsed > delay) begin
            send_held();
            r.transmit = 1'b1;
          end
        end
      end
      ACT_SEND_ACK: begin
        awaited = w.pkt_number;
        timeout = w.wait_ticks;
        start_timer();
        send_held();
        r.transmit = 1'b1;
      end
      ACT_SEND: begin
        send_held();
        r.transmit = 1'b1;
      end
      ACT_SEND_DELAY: begin
        delay   = w.wait_ticks;
        awaited = NONE_AWAITED;
        start_timer();
      end
      ACT_RX_HDR: begin
        if (w.dest_addr == link_cfg.own_id ||
            (w.dest_addr == BCAST_ADDR && w.pkt_number != last_bcast)) begin
          r.accepted = 1'b1;
          last_bcast = w.pkt_number;
          if (awaited != NONE_AWAITED && w.pkt_type == TYPE_ACK) begin
            awaited   = NONE_AWAITED;
            timer_run = 1'b0;
            r.ack_seen = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.failed   = fail_flag;
    r.timer_on = timer_run;
    return r;
  endfunction

  always @(posedge clk) begin
    arq_item_t   w;
    arq_result_t got;
    arq_result_t want;
    if (!rst_n) begin
      clear_link();
      expected_results.delete();
    end else begin
      // a result word always belongs to an earlier input word, so pop first
      if (out_valid && out_ready) begin
        got = {out_transmit, out_accepted, out_ack_seen, out_failed, out_timer_on};
        if (expected_results.size() == 0) begin
          $error("result word with no input word waiting for it");
          errs++;
        end else begin
          want = expected_results.pop_front();
          for (int b = 4; b >= 0; b--) begin
            if (got[b] !== want[b]) begin
              $error("%s: expected %0b, got %0b", field_name[b], want[b], got[b]);
              errs++;
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        w = {in_action, in_dest_addr, in_pkt_number, in_pkt_type, in_wait_ticks};
        expected_results.push_back(link_step(w));
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_OWN_ID:      link_cfg.own_id = cfg_wdata;
          CFG_MAX_RESENDS: link_cfg.max_resends = cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
    error_count   <= errs;
    words_pending <= expected_results.size();
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the stop-and-wait link controller: a directed pass over the
// special cases, a long tick run for retry saturation, then random link
// exchanges under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import arq_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RX_HOLD_CYCLES = 500;
  localparam int PHASE_WORDS    = 200;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [2:0]            in_action;
  logic [15:0]           in_dest_addr;
  logic [15:0]           in_pkt_number;
  logic [7:0]            in_pkt_type;
  logic [15:0]           in_wait_ticks;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_transmit;
  logic                  out_accepted;
  logic                  out_ack_seen;
  logic                  out_failed;
  logic                  out_timer_on;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int          err_count;
  int          pending;
  int          words_sent = 0;
  int          quiet_cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          rx_hold_req = 1'b0;
  logic [15:0] cur_own = 16'h0000;

  ack_retransmit_controller_unit dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_action, .in_dest_addr, .in_pkt_number,
    .in_pkt_type, .in_wait_ticks,
    .out_valid, .out_ready, .out_transmit, .out_accepted, .out_ack_seen,
    .out_failed, .out_timer_on,
    .cfg_wr_en, .cfg_index, .cfg_wdata
  );

  arq_checker link_check (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_action, .in_dest_addr, .in_pkt_number,
    .in_pkt_type, .in_wait_ticks,
    .out_valid, .out_ready, .out_transmit, .out_accepted, .out_ack_seen,
    .out_failed, .out_timer_on,
    .cfg_wr_en, .cfg_index, .cfg_wdata,
    .error_count(err_count),
    .words_pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic push_word(logic [2:0] act, logic [15:0] addr, logic [15:0] num,
                           logic [7:0] typ, logic [15:0] wt);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_dest_addr  <= addr;
    in_pkt_number <= num;
    in_pkt_type   <= typ;
    in_wait_ticks <= wt;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic push_tick();
    push_word(ACT_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // small number pool so broadcast repeats actually happen
  function automatic logic [15:0] pick_num();
    return ($urandom_range(9) < 6) ? 16'($urandom_range(3)) : 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_addr();
    int r;
    r = $urandom_range(9);
    if (r < 4) return cur_own;
    if (r < 7) return BCAST_ADDR;
    return 16'($urandom);
  endfunction

  task automatic push_header();
    push_word(ACT_RX_HDR, pick_addr(), pick_num(),
              $urandom_range(1) ? TYPE_ACK : 8'($urandom), 16'($urandom));
  endtask

  // sender pause: wait for every result, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] own, logic [7:0] limit);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_OWN_ID;
    cfg_wdata <= own;
    @(posedge clk);
    cfg_index <= CFG_MAX_RESENDS;
    cfg_wdata <= {8'($urandom), limit};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_own = own;
  endtask

  task automatic run_scenario();
    int kind;
    int n;
    kind = $urandom_range(9);
    if (kind < 4) begin
      // send, let it time out a few times, maybe get acked
      push_word(ACT_SEND_ACK, 16'($urandom),
                ($urandom_range(9) == 0) ? NONE_AWAITED : pick_num(), 8'($urandom),
                ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(3)));
      n = $urandom_range(14);
      repeat (n) begin
        if ($urandom_range(4) == 0) push_header();
        else push_tick();
      end
      if ($urandom_range(9) < 6) begin
        push_word(ACT_RX_HDR, pick_addr(), pick_num(), TYPE_ACK, 16'($urandom));
      end
    end else if (kind < 6) begin
      push_word(ACT_SEND_DELAY, 16'($urandom), 16'($urandom), 8'($urandom),
                ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(4)));
      n = $urandom_range(8);
      repeat (n) push_tick();
      if (kind == 5) begin
        push_word(ACT_SEND, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
      end
    end else if (kind < 8) begin
      n = $urandom_range(1, 4);
      repeat (n) push_header();
    end else if (kind == 8) begin
      push_word(3'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
    end else begin
      push_word(ACT_SEND, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
      push_tick();
    end
  endtask

  initial begin
    int target;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = ACT_TICK;
    in_dest_addr  = '0;
    in_pkt_number = '0;
    in_pkt_type   = '0;
    in_wait_ticks = '0;
    cfg_wr_en     = 1'b0;
    cfg_index     = CFG_OWN_ID;
    cfg_wdata     = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: own address zero, so a broadcast matches as unicast
    push_word(ACT_RX_HDR, BCAST_ADDR, 16'h0000, TYPE_ACK, 16'h0000);
    push_word(ACT_RX_HDR, BCAST_ADDR, 16'h0000, 8'hff, 16'hffff);
    push_tick();
    for (int a = ACT_RX_HDR + 1; a < 8; a++) begin
      push_word(3'(a), 16'hffff, 16'hffff, 8'hff, 16'hffff);
    end
    push_word(ACT_SEND, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    // zero timeout: retransmit on every tick until the retry limit trips
    push_word(ACT_SEND_ACK, 16'hffff, 16'hffff, TYPE_ACK, 16'h0000);
    repeat (7) push_tick();
    push_word(ACT_SEND_DELAY, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    repeat (2) push_tick();
    push_word(ACT_SEND_DELAY, 16'h0000, 16'h0000, 8'h00, 16'd2);
    repeat (3) push_tick();
    push_word(ACT_SEND_ACK, 16'h0000, 16'd1, 8'h00, 16'd1);
    push_word(ACT_RX_HDR, 16'hffff, 16'd1, TYPE_ACK, 16'h0000);
    push_word(ACT_RX_HDR, BCAST_ADDR, 16'd1, TYPE_ACK, 16'h0000);

    wait_idle();
    set_regs(16'hffff, 8'd0);
    push_word(ACT_SEND_ACK, 16'h0000, NONE_AWAITED, 8'h00, 16'hffff);
    push_word(ACT_RX_HDR, BCAST_ADDR, 16'd5, 8'hff, 16'h0000);
    push_word(ACT_RX_HDR, BCAST_ADDR, 16'd5, 8'hff, 16'h0000);
    push_word(ACT_RX_HDR, 16'hffff, 16'd5, 8'hff, 16'h0000);
    push_word(ACT_SEND_ACK, 16'h0000, 16'd7, 8'h00, 16'h0000);
    push_tick();

    wait_idle();
    set_regs(16'h5a5a, 8'd255);
    // retry count saturates at 255, never above a limit of 255, so it never fails
    push_word(ACT_SEND_ACK, 16'h0000, 16'h0042, 8'h00, 16'h0000);
    repeat (300) push_tick();

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0: set_regs(16'($urandom), MAX_RESENDS_RST);
        1: set_regs(16'hffff, 8'd0);
        2: set_regs(16'($urandom), 8'd255);
        3: set_regs(16'h0000, 8'($urandom_range(1, 3)));
        4: set_regs(16'($urandom), 8'($urandom_range(3)));
        5: set_regs(16'h0001, 8'd2);
        6: set_regs(16'($urandom), 8'd255);
        default: set_regs(16'($urandom), 8'($urandom));
      endcase
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
        default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
      endcase
      // long result hold-off while the sender keeps going fills the pipe
      if (ph == 0) rx_hold_req = 1'b1;
      target = words_sent + PHASE_WORDS / 2;
      while (words_sent < target) run_scenario();
      wait_idle();
      target = words_sent + PHASE_WORDS / 2;
      while (words_sent < target) run_scenario();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
